@@ rtl/tbrl_pkg.sv @@
// Package for the token bucket rate limiter: field widths, fixed-point
// constants, operation and register codes, unit status struct.
// No dependencies.
package tbrl_pkg;

    localparam int OP_W      = 2;
    localparam int ELAPSED_W = 32;
    localparam int RATE_W    = 32;
    localparam int CAP_W     = 16;
    localparam int WHOLE_W   = 16;
    localparam int RETRY_W   = 17;
    localparam int LEVEL_W   = 52;
    localparam int MICRO_W   = 20;
    localparam int PROD_W    = 66;
    localparam int NUM_W     = 36;
    localparam int QUOT_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int MUL_STEPS = 32;

    localparam logic [LEVEL_W-1:0] ONE_TOKEN_UNITS = 52'd65536000000;
    localparam logic [MICRO_W-1:0] MICRO_PER_SEC   = 20'd1000000;
    localparam logic [RETRY_W-1:0] RETRY_MAX       = 17'd65536;

    localparam logic [RATE_W-1:0]  RATE_RESET    = 32'd655360;
    localparam logic [CAP_W-1:0]   CAP_RESET     = 16'd20;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET   = 52'd1310720000000;
    localparam logic [LEVEL_W-1:0] DIVISOR_RESET = 52'd655360000000;

    localparam logic [OP_W-1:0] OP_PASS    = 2'd0;
    localparam logic [OP_W-1:0] OP_CONSUME = 2'd1;
    localparam logic [OP_W-1:0] OP_REFILL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_RATE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_CAPACITY = 1'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

@@ rtl/tbrl_in_if.sv @@
// Input channel of the token bucket rate limiter: valid/ready plus request fields.
// Depends on tbrl_pkg.
interface tbrl_in_if import tbrl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [ELAPSED_W-1:0] elapsed_us;

    modport source (output valid, output operation, output elapsed_us, input ready);
    modport sink   (input valid, input operation, input elapsed_us, output ready);
endinterface

@@ rtl/tbrl_out_if.sv @@
// Output channel of the token bucket rate limiter: valid/ready plus result fields.
// Depends on tbrl_pkg.
interface tbrl_out_if import tbrl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               granted;
    logic [WHOLE_W-1:0] whole_tokens;
    logic [RETRY_W-1:0] retry_seconds;

    modport source (output valid, output granted, output whole_tokens,
                    output retry_seconds, input ready);
    modport sink   (input valid, input granted, input whole_tokens,
                    input retry_seconds, output ready);
endinterface

@@ rtl/token_bucket_rate_limiter.sv @@
// Token bucket rate limiter top level: configuration, sequencer, bucket level.
// Depends on tbrl_pkg, tbrl_in_if, tbrl_out_if, tbrl_mul, tbrl_div.
//
//  channel  | dir | transaction contents
//  ---------+-----+--------------------------------------------------
//  i_in     | in  | operation[1:0], elapsed_us[31:0]
//  o_out    | out | granted, whole_tokens[15:0], retry_seconds[16:0]
//  i_cfg_*  | in  | write: index 0 token_rate, 1 bucket_capacity
//
// A transaction passes from accept to result through the bit-serial multiplier
// (one elapsed_us bit per cycle, a final fold and the hand-back), the serial
// divider (one quotient bit per cycle plus the hand-back) and the sequencing
// states S_SAT, S_OP, S_PREP and S_DONE.
// A transaction with a zero rate that comes up short skips the divider.
// The next request is taken the cycle after the result enters the output register.
// Reset is synchronous, active low; it fills the bucket to capacity at once.
// A stalled output holds its result; a new request is processed meanwhile and
// waits in the final state until the output register frees.
module token_bucket_rate_limiter import tbrl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tbrl_in_if.sink               i_in,
    tbrl_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SAT,
        S_OP,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    // configuration and derived scale factors
    logic [RATE_W-1:0]  r_token_rate;
    logic [CAP_W-1:0]   r_bucket_capacity;
    logic [LEVEL_W-1:0] r_cap_units;
    logic [LEVEL_W-1:0] r_divisor;

    // sequencer and bucket state
    t_state             r_state, n_state;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [OP_W-1:0]    r_op;
    logic               r_elapsed_zero;
    logic               r_granted, n_granted;
    logic               r_short, n_short;
    logic               r_rate_zero, n_rate_zero;

    // output register
    logic               r_out_valid, n_out_valid;
    logic               r_out_granted, n_out_granted;
    logic [WHOLE_W-1:0] r_out_whole, n_out_whole;
    logic [RETRY_W-1:0] r_out_retry, n_out_retry;

    // serial units
    logic               in_fire;
    logic [PROD_W-1:0]  mul_sum;
    t_unit_stat         mul_stat;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [LEVEL_W-1:0] div_den;
    logic [QUOT_W-1:0]  div_quot;
    t_unit_stat         div_stat;
    logic [LEVEL_W-1:0] deficit_m1;
    logic [LEVEL_W-FRAC_W-1:0] cap_scaled;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;

    // level + elapsed * rate, accumulated serially
    tbrl_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_fire),
        .i_mcand  (r_token_rate),
        .i_mplier (i_in.elapsed_us),
        .i_addend (r_level),
        .o_sum    (mul_sum),
        .o_stat   (mul_stat)
    );

    // shared divider: whole tokens when at least one is held, else retry wait at a nonzero rate
    tbrl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_quot),
        .o_stat  (div_stat)
    );

    assign cap_scaled = {{(NUM_W-CAP_W){1'b0}}, r_bucket_capacity}
                      * {{(NUM_W-MICRO_W){1'b0}}, MICRO_PER_SEC};
    assign deficit_m1 = ONE_TOKEN_UNITS - r_level - LEVEL_W'(1);

    always_comb begin
        n_state       = r_state;
        n_level       = r_level;
        n_granted     = r_granted;
        n_short       = r_short;
        n_rate_zero   = r_rate_zero;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_granted = r_out_granted;
        n_out_whole   = r_out_whole;
        n_out_retry   = r_out_retry;
        div_start     = 1'b0;
        div_num       = r_level[LEVEL_W-1:FRAC_W];
        div_den       = {{(LEVEL_W-MICRO_W){1'b0}}, MICRO_PER_SEC};

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_stat.done) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                // refill by time and clamp at capacity; zero time leaves the level alone
                if (!r_elapsed_zero) begin
                    if ((r_level >= r_cap_units) ||
                        (mul_sum >= {{(PROD_W-LEVEL_W){1'b0}}, r_cap_units})) begin
                        n_level = r_cap_units;
                    end else begin
                        n_level = mul_sum[LEVEL_W-1:0];
                    end
                end
                n_state = S_OP;
            end
            S_OP: begin
                n_granted = 1'b0;
                case (r_op)
                    OP_CONSUME: begin
                        if (r_level >= ONE_TOKEN_UNITS) begin
                            n_level   = r_level - ONE_TOKEN_UNITS;
                            n_granted = 1'b1;
                        end
                    end
                    OP_REFILL: begin
                        n_level = r_cap_units;
                    end
                    default: begin
                    end
                endcase
                n_state = S_PREP;
            end
            S_PREP: begin
                n_short     = (r_level < ONE_TOKEN_UNITS);
                n_rate_zero = (r_token_rate == '0);
                if (r_level >= ONE_TOKEN_UNITS) begin
                    // whole tokens: (level >> 16) / 10^6
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else if (r_token_rate != '0) begin
                    // retry wait: ceil(deficit / divisor) = floor((deficit - 1) / divisor) + 1
                    div_start = 1'b1;
                    div_num   = deficit_m1[NUM_W-1:0];
                    div_den   = r_divisor;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // load the output register once it is free or being drained
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_granted = r_granted;
                    if (r_short) begin
                        n_out_whole = '0;
                        n_out_retry = r_rate_zero ? RETRY_MAX
                                                  : ({1'b0, div_quot} + RETRY_W'(1));
                    end else begin
                        n_out_whole = div_quot;
                        n_out_retry = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_token_rate      <= RATE_RESET;
            r_bucket_capacity <= CAP_RESET;
            r_cap_units       <= LEVEL_RESET;
            r_divisor         <= DIVISOR_RESET;
            r_level           <= LEVEL_RESET;
            r_out_valid       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
            // scale factors are registered from the configuration registers and follow them in the next cycle
            r_cap_units <= {cap_scaled, {FRAC_W{1'b0}}};
            r_divisor   <= {{(LEVEL_W-RATE_W){1'b0}}, r_token_rate}
                         * {{(LEVEL_W-MICRO_W){1'b0}}, MICRO_PER_SEC};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOKEN_RATE: begin
                        r_token_rate <= i_cfg_data[RATE_W-1:0];
                    end
                    CFG_BUCKET_CAPACITY: begin
                        r_bucket_capacity <= i_cfg_data[CAP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (in_fire) begin
            r_op           <= i_in.operation;
            r_elapsed_zero <= (i_in.elapsed_us == '0);
        end
        r_granted     <= n_granted;
        r_short       <= n_short;
        r_rate_zero   <= n_rate_zero;
        r_out_granted <= n_out_granted;
        r_out_whole   <= n_out_whole;
        r_out_retry   <= n_out_retry;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.granted       = r_out_granted;
    assign o_out.whole_tokens  = r_out_whole;
    assign o_out.retry_seconds = r_out_retry;

    // the multiplier is only ever busy while a transaction is in flight
    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mul_stat.busy)
        else $error("multiplier busy while idle");

    // time refill never leaves the level above capacity
    a_sat_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SAT && !r_elapsed_zero) |=> (r_level <= $past(r_cap_units)))
        else $error("level above capacity after refill");

    // while waiting on the divider it is running or just finished
    a_div_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("divider stalled");

    // leaving the final state always presents a result
    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && n_state == S_IDLE) |=> r_out_valid)
        else $error("result not loaded");

endmodule

@@ rtl/tbrl_mul.sv @@
// Bit-serial multiply-accumulate: sum = mcand * mplier + addend, one multiplier
// bit per cycle, low addend bits fed in serially, the rest folded in at the end. Depends on tbrl_pkg.
module tbrl_mul import tbrl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [RATE_W-1:0]    i_mcand,
    input  logic [ELAPSED_W-1:0] i_mplier,
    input  logic [LEVEL_W-1:0]   i_addend,
    output logic [PROD_W-1:0]    o_sum,
    output t_unit_stat           o_stat
);
    localparam int CNT_W = $clog2(MUL_STEPS + 1);
    localparam int HI_W  = PROD_W - ELAPSED_W;

    logic [HI_W-1:0]      r_hi;
    logic [ELAPSED_W-1:0] r_lo;
    logic [LEVEL_W-1:0]   r_add;
    logic [RATE_W-1:0]    r_mcand;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [HI_W-1:0]      step_sum;

    // Add the selected partial product and one addend bit at the low end of the high half.
    assign step_sum = r_hi
                    + (r_lo[0] ? {{(HI_W-RATE_W){1'b0}}, r_mcand} : {HI_W{1'b0}})
                    + {{(HI_W-1){1'b0}}, r_add[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_hi    <= '0;
                r_lo    <= i_mplier;
                r_add   <= i_addend;
                r_mcand <= i_mcand;
                r_cnt   <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt != CNT_W'(MUL_STEPS)) begin
                    r_hi  <= {1'b0, step_sum[HI_W-1:1]};
                    r_lo  <= {step_sum[0], r_lo[ELAPSED_W-1:1]};
                    r_add <= r_add >> 1;
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    // fold in the addend bits above the low half
                    r_hi   <= r_hi + {{(HI_W-(LEVEL_W-ELAPSED_W)){1'b0}},
                                      r_add[LEVEL_W-ELAPSED_W-1:0]};
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sum       = {r_hi, r_lo};
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule

@@ rtl/tbrl_div.sv @@
// Restoring divider, one quotient bit per cycle, for quotients that fit 16 bits.
// Depends on tbrl_pkg.
module tbrl_div import tbrl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [LEVEL_W-1:0] i_den,
    output logic [QUOT_W-1:0]  o_quot,
    output t_unit_stat         o_stat
);
    localparam int DEN_W = LEVEL_W + QUOT_W - 1;
    localparam int CNT_W = $clog2(QUOT_W);

    logic [NUM_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              fits;

    assign fits = (r_den[DEN_W-1:NUM_W] == '0) && (r_den[NUM_W-1:0] <= r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_den  <= {i_den, {(QUOT_W-1){1'b0}}};
                r_quot <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (fits) begin
                    r_rem <= r_rem - r_den[NUM_W-1:0];
                end
                r_quot <= {r_quot[QUOT_W-2:0], fits};
                r_den  <= r_den >> 1;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule
